// ===== rtl/tlb_pkg.sv =====
// shared types and constants of the tiled light binner
package tlb_pkg;

	localparam int TILES_PER_SIDE = 64;
	localparam int TILE_BITS = $clog2(TILES_PER_SIDE);
	localparam int NUM_TILES = TILES_PER_SIDE * TILES_PER_SIDE;
	localparam int TILE_IDX_BITS = 2 * TILE_BITS;
	localparam int LIST_DEPTH = 32;
	localparam int SLOTS = LIST_DEPTH - 1;
	localparam int CNT_BITS = $clog2(LIST_DEPTH);
	localparam int LIST_ENTRIES = NUM_TILES * SLOTS;
	localparam int LIST_ADDR_BITS = $clog2(LIST_ENTRIES);
	localparam int ID_BITS = 16;

	localparam int COORD_BITS = 24;
	localparam int DEPTH_BITS = 17;
	localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = 17'h10000;
	localparam int FRAC_BITS = 16;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_BIN   = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	typedef struct packed {
		func_t                 op;
		logic [ID_BITS-1:0]    id;
		logic [TILE_BITS-1:0]  x0;
		logic [TILE_BITS-1:0]  x1;
		logic [TILE_BITS-1:0]  y0;
		logic [TILE_BITS-1:0]  y1;
		logic [DEPTH_BITS-1:0] depth;
		logic [5:0]            col;
		logic [5:0]            row;
		logic [4:0]            slot;
	} cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]   cnt;
		logic [DEPTH_BITS-1:0] depth;
	} tile_rec_t;

	typedef struct packed {
		logic [4:0]            cnt;
		logic [15:0]           light;
		logic                  valid;
		logic [DEPTH_BITS-1:0] depth;
	} res_t;

endpackage

// ===== rtl/tiled_light_binner_unit.sv =====
// top level of the tiled light binner
// Bins lights into a 64x64 tile grid with up to 31 light ids per tile. After reset the
// tile memory is swept one tile a cycle while full stays high. Items then go through a
// two-entry command queue to a sequencer that owns the tile memories: a clear item sweeps
// the grid one tile a cycle, a bin item reads and then writes the tile record of each
// covered tile in turn, and a read item reads the tile record and list entry and then
// waits for room in the two-entry result queue. Func value 3 is dropped at the input
// and never queued.
module tiled_light_binner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [15:0] light_id,
	input  logic signed [23:0] ndc_min_x,
	input  logic signed [23:0] ndc_max_x,
	input  logic signed [23:0] ndc_min_y,
	input  logic signed [23:0] ndc_max_y,
	input  logic [16:0] light_near_depth,
	input  logic [5:0]  tile_col,
	input  logic [5:0]  tile_row,
	input  logic [4:0]  list_slot,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  tile_light_count,
	output logic [15:0] slot_light,
	output logic        slot_valid,
	output logic [16:0] tile_near_depth
);

	tlb_pkg::cmd_t front_cmd;
	tlb_pkg::cmd_t back_cmd;
	tlb_pkg::res_t back_res;
	tlb_pkg::res_t out_res;
	logic cmd_used;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	logic init_busy;
	logic accept;

	assign full   = cmd_full | init_busy;
	assign accept = push & ~full;

	tlb_front u_front (
		.func             (func),
		.light_id         (light_id),
		.ndc_min_x        (ndc_min_x),
		.ndc_max_x        (ndc_max_x),
		.ndc_min_y        (ndc_min_y),
		.ndc_max_y        (ndc_max_y),
		.light_near_depth (light_near_depth),
		.tile_col         (tile_col),
		.tile_row         (tile_row),
		.list_slot        (list_slot),
		.cmd_used         (cmd_used),
		.cmd              (front_cmd)
	);

	// unused func codes are taken as a transaction but never queued
	tlb_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept & cmd_used),
		.wr_data (front_cmd),
		.q_full  (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (back_cmd),
		.q_empty (cmd_empty)
	);

	tlb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res),
		.init_busy (init_busy)
	);

	tlb_res_queue u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (back_res),
		.q_full  (res_full),
		.rd_en   (pop & ~empty),
		.rd_data (out_res),
		.q_empty (empty)
	);

	assign tile_light_count = out_res.cnt;
	assign slot_light       = out_res.light;
	assign slot_valid       = out_res.valid;
	assign tile_near_depth  = out_res.depth;

endmodule

// ===== rtl/tlb_front.sv =====
// front end: classifies an incoming item and turns light bounds into tile ranges
module tlb_front (
	input  logic [1:0]  func,
	input  logic [15:0] light_id,
	input  logic signed [23:0] ndc_min_x,
	input  logic signed [23:0] ndc_max_x,
	input  logic signed [23:0] ndc_min_y,
	input  logic signed [23:0] ndc_max_y,
	input  logic [16:0] light_near_depth,
	input  logic [5:0]  tile_col,
	input  logic [5:0]  tile_row,
	input  logic [4:0]  list_slot,
	output logic        cmd_used,
	output tlb_pkg::cmd_t cmd
);

	localparam int PROD_BITS = tlb_pkg::COORD_BITS + tlb_pkg::TILE_BITS + 2;
	localparam int SHIFT = tlb_pkg::FRAC_BITS + 1;
	localparam int T_BITS = PROD_BITS - SHIFT;
	localparam logic [PROD_BITS-1:0] ROUND_UP = PROD_BITS'((1 << SHIFT) - 1);
	localparam logic [T_BITS-1:0] T_MAX = T_BITS'(tlb_pkg::TILES_PER_SIDE - 1);

	// tile = (x + 1) * tiles / 2, floor or ceil, clamped to the grid
	function automatic logic [tlb_pkg::TILE_BITS-1:0] tile_index(
		input logic signed [23:0] raw,
		input logic               ceil_mode
	);
		logic [24:0]          v;
		logic [PROD_BITS-1:0] p;
		logic [T_BITS-1:0]    t;
		v = {raw[23], raw} + 25'h010000;
		p = PROD_BITS'(v[23:0]) * PROD_BITS'(tlb_pkg::TILES_PER_SIDE);
		if (ceil_mode) begin
			p = p + ROUND_UP;
		end
		t = p[PROD_BITS-1:SHIFT];
		if (t > T_MAX) begin
			t = T_MAX;
		end
		if (v[24] || v == 25'd0) begin
			t = '0;
		end
		return tlb_pkg::TILE_BITS'(t);
	endfunction

	always_comb begin
		case (func)
			tlb_pkg::FUNC_CLEAR,
			tlb_pkg::FUNC_BIN,
			tlb_pkg::FUNC_READ: cmd_used = 1'b1;
			default:            cmd_used = 1'b0;
		endcase
		cmd.op    = tlb_pkg::func_t'(func);
		cmd.id    = tlb_pkg::ID_BITS'(light_id);
		cmd.x0    = tile_index(ndc_min_x, 1'b0);
		cmd.x1    = tile_index(ndc_max_x, 1'b1);
		cmd.y0    = tile_index(ndc_min_y, 1'b0);
		cmd.y1    = tile_index(ndc_max_y, 1'b1);
		cmd.depth = (light_near_depth > tlb_pkg::DEPTH_ONE) ? tlb_pkg::DEPTH_ONE
		                                                    : light_near_depth;
		cmd.col   = tile_col;
		cmd.row   = tile_row;
		cmd.slot  = list_slot;
	end

endmodule

// ===== rtl/tlb_cmd_queue.sv =====
// two-entry queue of classified commands between front and back
module tlb_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tlb_pkg::cmd_t wr_data,
	output logic          q_full,
	input  logic          rd_en,
	output tlb_pkg::cmd_t rd_data,
	output logic          q_empty
);

	tlb_pkg::cmd_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/tlb_res_queue.sv =====
// two-entry queue of read results toward the output ports
module tlb_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tlb_pkg::res_t wr_data,
	output logic          q_full,
	input  logic          rd_en,
	output tlb_pkg::res_t rd_data,
	output logic          q_empty
);

	tlb_pkg::res_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/tlb_back.sv =====
// back end: sequencer that sweeps, bins and reads the tile memories
module tlb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  tlb_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output tlb_pkg::res_t res,
	output logic          init_busy
);

	typedef enum logic [5:0] {
		ST_CLEAR    = 6'b000001,
		ST_IDLE     = 6'b000010,
		ST_BIN_RD   = 6'b000100,
		ST_BIN_WR   = 6'b001000,
		ST_READ_RD  = 6'b010000,
		ST_READ_OUT = 6'b100000
	} state_t;

	localparam int TB = tlb_pkg::TILE_BITS;
	localparam int AB = tlb_pkg::LIST_ADDR_BITS;

	state_t state_q, state_d;
	logic [tlb_pkg::TILE_IDX_BITS-1:0] clr_idx_q;
	logic init_q;

	tlb_pkg::cmd_t cmd_q;
	logic [TB-1:0] r_q;
	logic [TB-1:0] c_q;

	tlb_pkg::tile_rec_t rec_mem [tlb_pkg::NUM_TILES];
	tlb_pkg::tile_rec_t rec_rd_q;
	logic [tlb_pkg::ID_BITS-1:0] list_mem [tlb_pkg::LIST_ENTRIES];
	logic [tlb_pkg::ID_BITS-1:0] list_rd_q;

	logic [tlb_pkg::TILE_IDX_BITS-1:0] tile;
	logic [AB-1:0] tile_base;
	logic [4:0]    slot_eff;
	logic [AB-1:0] list_raddr;
	logic [AB-1:0] list_waddr;
	logic          list_we;
	logic          rec_we;
	logic [tlb_pkg::TILE_IDX_BITS-1:0] rec_waddr;
	tlb_pkg::tile_rec_t rec_wdata;
	logic          room;
	logic          last_col;
	logic          last_row;
	logic          clr_last;

	assign tile      = {r_q, c_q};
	assign tile_base = AB'(tile) * AB'(tlb_pkg::SLOTS);
	// a slot past the list never reads as valid, keep its address in range
	assign slot_eff   = (cmd_q.slot < 5'(tlb_pkg::SLOTS)) ? cmd_q.slot : 5'd0;
	assign list_raddr = tile_base + AB'(slot_eff);
	assign list_waddr = tile_base + AB'(rec_rd_q.cnt);
	assign room       = (rec_rd_q.cnt < tlb_pkg::CNT_BITS'(tlb_pkg::SLOTS));
	assign last_col   = (c_q == cmd_q.x1);
	assign last_row   = (r_q == cmd_q.y1);
	assign clr_last   = (clr_idx_q == tlb_pkg::TILE_IDX_BITS'(tlb_pkg::NUM_TILES - 1));
	assign init_busy  = init_q;

	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;

	always_comb begin
		state_d   = state_q;
		rec_we    = 1'b0;
		rec_waddr = tile;
		rec_wdata = rec_rd_q;
		list_we   = 1'b0;
		res_push  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				rec_we          = 1'b1;
				rec_waddr       = clr_idx_q;
				rec_wdata.cnt   = '0;
				rec_wdata.depth = tlb_pkg::DEPTH_ONE;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.op)
						tlb_pkg::FUNC_CLEAR: state_d = ST_CLEAR;
						tlb_pkg::FUNC_BIN: begin
							// inverted bounds touch no tile
							if (cmd.x0 > cmd.x1 || cmd.y0 > cmd.y1) begin
								state_d = ST_IDLE;
							end else begin
								state_d = ST_BIN_RD;
							end
						end
						tlb_pkg::FUNC_READ: state_d = ST_READ_RD;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_BIN_RD: state_d = ST_BIN_WR;
			ST_BIN_WR: begin
				if (room) begin
					rec_we          = 1'b1;
					list_we         = 1'b1;
					rec_wdata.cnt   = rec_rd_q.cnt + tlb_pkg::CNT_BITS'(1);
					rec_wdata.depth = (cmd_q.depth < rec_rd_q.depth) ? cmd_q.depth
					                                                  : rec_rd_q.depth;
				end
				if (last_col && last_row) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_BIN_RD;
				end
			end
			ST_READ_RD: state_d = ST_READ_OUT;
			ST_READ_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		res.cnt   = 5'(rec_rd_q.cnt);
		res.depth = rec_rd_q.depth;
		res.valid = (cmd_q.slot < 5'(rec_rd_q.cnt));
		res.light = res.valid ? 16'(list_rd_q) : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			init_q    <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + tlb_pkg::TILE_IDX_BITS'(1);
				if (clr_last) begin
					init_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
			if (cmd.op == tlb_pkg::FUNC_READ) begin
				r_q <= TB'(cmd.row);
				c_q <= TB'(cmd.col);
			end else begin
				r_q <= cmd.y0;
				c_q <= cmd.x0;
			end
		end else if (state_q == ST_BIN_WR) begin
			if (last_col) begin
				c_q <= cmd_q.x0;
				r_q <= r_q + TB'(1);
			end else begin
				c_q <= c_q + TB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rd_q <= rec_mem[tile];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= cmd_q.id;
		end
		list_rd_q <= list_mem[list_raddr];
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for the tiled light binner: queued stimulus, tile grid predictor, result checker
module tb_top;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int RAND_ITEMS = 600;
	localparam int TAIL_ITEMS = 60;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 9000;

	typedef struct {
		logic [1:0]         func;
		logic [15:0]        id;
		logic signed [23:0] min_x;
		logic signed [23:0] max_x;
		logic signed [23:0] min_y;
		logic signed [23:0] max_y;
		logic [16:0]        depth;
		logic [5:0]         col;
		logic [5:0]         row;
		logic [4:0]         slot;
	} light_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [1:0] func = '0;
	logic [15:0] light_id = '0;
	logic signed [23:0] ndc_min_x = '0;
	logic signed [23:0] ndc_max_x = '0;
	logic signed [23:0] ndc_min_y = '0;
	logic signed [23:0] ndc_max_y = '0;
	logic [16:0] light_near_depth = '0;
	logic [5:0] tile_col = '0;
	logic [5:0] tile_row = '0;
	logic [4:0] list_slot = '0;
	logic [4:0] tile_light_count;
	logic [15:0] slot_light;
	logic slot_valid;
	logic [16:0] tile_near_depth;

	// predicted tile grid
	logic [4:0]  tile_count [tlb_pkg::NUM_TILES];
	logic [16:0] tile_depth [tlb_pkg::NUM_TILES];
	logic [15:0] tile_ids [tlb_pkg::LIST_ENTRIES];

	light_cmd_t stim_items[$];
	tlb_pkg::res_t expected_reads[$];
	int stim_total = 0;
	int items_taken = 0;
	int err_count = 0;
	logic in_taken = 1'b0;
	logic tail_run = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int hold_at = 0;

	tiled_light_binner_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.light_id(light_id),
		.ndc_min_x(ndc_min_x),
		.ndc_max_x(ndc_max_x),
		.ndc_min_y(ndc_min_y),
		.ndc_max_y(ndc_max_y),
		.light_near_depth(light_near_depth),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.list_slot(list_slot),
		.empty(empty),
		.pop(pop),
		.tile_light_count(tile_light_count),
		.slot_light(slot_light),
		.slot_valid(slot_valid),
		.tile_near_depth(tile_near_depth)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("tiled_light_binner_unit: mismatch");
		$finish;
	end

	// tile index of a Q8.16 bound: t = (x + 1) * 32, floor or ceil, clamped to the grid
	function automatic int tile_of(logic signed [23:0] x, bit round_up);
		longint v;
		longint p;
		v = longint'(x) + 65536;
		if (v <= 0)
			return 0;
		p = v * tlb_pkg::TILES_PER_SIDE;
		if (round_up)
			p = p + 131071;
		p = p >>> 17;
		if (p > tlb_pkg::TILES_PER_SIDE - 1)
			p = tlb_pkg::TILES_PER_SIDE - 1;
		return int'(p);
	endfunction

	function automatic void tiles_clear();
		for (int i = 0; i < tlb_pkg::NUM_TILES; i++) begin
			tile_count[i] = '0;
			tile_depth[i] = tlb_pkg::DEPTH_ONE;
		end
	endfunction

	function automatic void tiles_add_light(logic [15:0] id, logic signed [23:0] x_lo,
			logic signed [23:0] x_hi, logic signed [23:0] y_lo, logic signed [23:0] y_hi,
			logic [16:0] depth);
		int x0, x1, y0, y1, t;
		logic [16:0] d;
		x0 = tile_of(x_lo, 1'b0);
		x1 = tile_of(x_hi, 1'b1);
		y0 = tile_of(y_lo, 1'b0);
		y1 = tile_of(y_hi, 1'b1);
		d = (depth > tlb_pkg::DEPTH_ONE) ? tlb_pkg::DEPTH_ONE : depth;
		for (int r = y0; r <= y1; r++) begin
			for (int c = x0; c <= x1; c++) begin
				t = r * tlb_pkg::TILES_PER_SIDE + c;
				// a full tile drops the light and keeps its depth
				if (tile_count[t] < tlb_pkg::SLOTS) begin
					tile_ids[t * tlb_pkg::SLOTS + tile_count[t]] = id;
					tile_count[t] = tile_count[t] + 5'd1;
					if (d < tile_depth[t])
						tile_depth[t] = d;
				end
			end
		end
	endfunction

	function automatic tlb_pkg::res_t tiles_lookup(logic [5:0] col, logic [5:0] row,
			logic [4:0] slot);
		tlb_pkg::res_t r;
		int t;
		r.cnt = '0;
		r.light = '0;
		r.valid = 1'b0;
		r.depth = tlb_pkg::DEPTH_ONE;
		if (col < tlb_pkg::TILES_PER_SIDE && row < tlb_pkg::TILES_PER_SIDE) begin
			t = int'(row) * tlb_pkg::TILES_PER_SIDE + int'(col);
			r.cnt = tile_count[t];
			r.depth = tile_depth[t];
			if (slot < tile_count[t] && slot < tlb_pkg::SLOTS) begin
				r.valid = 1'b1;
				r.light = tile_ids[t * tlb_pkg::SLOTS + slot];
			end
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			err_count++;
		end
	endfunction

	// stimulus builders: unused fields carry random junk
	function automatic light_cmd_t noise_cmd(logic [1:0] f);
		light_cmd_t c;
		c.func = f;
		c.id = 16'($urandom());
		c.min_x = 24'($urandom());
		c.max_x = 24'($urandom());
		c.min_y = 24'($urandom());
		c.max_y = 24'($urandom());
		c.depth = 17'($urandom());
		c.col = 6'($urandom());
		c.row = 6'($urandom());
		c.slot = 5'($urandom_range(0, 30));
		return c;
	endfunction

	function automatic void queue_op(logic [1:0] f);
		stim_items.push_back(noise_cmd(f));
	endfunction

	function automatic void queue_light(logic [15:0] id, logic signed [23:0] x_lo,
			logic signed [23:0] x_hi, logic signed [23:0] y_lo, logic signed [23:0] y_hi,
			logic [16:0] depth);
		light_cmd_t c;
		c = noise_cmd(tlb_pkg::FUNC_BIN);
		c.id = id;
		c.min_x = x_lo;
		c.max_x = x_hi;
		c.min_y = y_lo;
		c.max_y = y_hi;
		c.depth = depth;
		stim_items.push_back(c);
	endfunction

	function automatic void queue_read(logic [5:0] col, logic [5:0] row, logic [4:0] slot);
		light_cmd_t c;
		c = noise_cmd(tlb_pkg::FUNC_READ);
		c.col = col;
		c.row = row;
		c.slot = slot;
		stim_items.push_back(c);
	endfunction

	// Q8.16 coordinate of the left edge of tile t plus a sub-tile offset
	function automatic logic signed [23:0] tile_coord(int t, int off);
		return 24'(t * 2048 - 65536 + off);
	endfunction

	function automatic logic [5:0] near_tile(int centre, int spread);
		int v;
		v = centre + $urandom_range(0, 2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > tlb_pkg::TILES_PER_SIDE - 1)
			v = tlb_pkg::TILES_PER_SIDE - 1;
		return 6'(v);
	endfunction

	function automatic logic [16:0] rand_depth();
		if ($urandom_range(0, 19) == 0)
			return 17'($urandom_range(65537, 131071));
		return 17'($urandom_range(0, 65536));
	endfunction

	function automatic logic [4:0] rand_slot();
		if ($urandom_range(0, 1) == 0)
			return 5'($urandom_range(0, 3));
		return 5'($urandom_range(0, 30));
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				void'(stim_items.pop_front());
				if (!tail_run && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 15);
			end
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (stim_items.size() > 0) begin
				push <= 1'b1;
				func <= stim_items[0].func;
				light_id <= stim_items[0].id;
				ndc_min_x <= stim_items[0].min_x;
				ndc_max_x <= stim_items[0].max_x;
				ndc_min_y <= stim_items[0].min_y;
				ndc_max_y <= stim_items[0].max_y;
				light_near_depth <= stim_items[0].depth;
				tile_col <= stim_items[0].col;
				tile_row <= stim_items[0].row;
				list_slot <= stim_items[0].slot;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && items_taken >= hold_at) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!tail_run && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// input and output transaction monitor
	always @(posedge clk) begin
		tlb_pkg::res_t want;
		if (arst_n) begin
			in_taken <= push && !full;
			tail_run <= (items_taken >= stim_total - TAIL_ITEMS);
			if (push && !full) begin
				items_taken <= items_taken + 1;
				case (func)
					tlb_pkg::FUNC_CLEAR: tiles_clear();
					tlb_pkg::FUNC_BIN: tiles_add_light(light_id, ndc_min_x, ndc_max_x,
						ndc_min_y, ndc_max_y, light_near_depth);
					tlb_pkg::FUNC_READ: expected_reads.push_back(tiles_lookup(tile_col,
						tile_row, list_slot));
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (expected_reads.size() == 0) begin
					$display("%0t: result with none expected, count %0d light %0d", $time,
						tile_light_count, slot_light);
					err_count++;
				end else begin
					want = expected_reads.pop_front();
					check_field("tile_light_count", 32'(want.cnt), 32'(tile_light_count));
					check_field("slot_light", 32'(want.light), 32'(slot_light));
					check_field("slot_valid", 32'(want.valid), 32'(slot_valid));
					check_field("tile_near_depth", 32'(want.depth), 32'(tile_near_depth));
				end
			end
		end
	end

	initial begin
		int hot_x, hot_y, seg_left, fill_n, pick, n_rand, cx, cy, wx, wy;
		tiles_clear();
		for (int i = 0; i < tlb_pkg::LIST_ENTRIES; i++)
			tile_ids[i] = '0;

		// directed: empty grid, spare func, whole-screen light with depth above one
		queue_read(6'd0, 6'd0, 5'd0);
		queue_op(FUNC_SPARE);
		queue_light(16'hFFFF, -24'sd8388608, 24'sd8388607, -24'sd8388608, 24'sd8388607,
			17'h1FFFF);
		queue_read(6'd63, 6'd63, 5'd0);
		queue_read(6'd17, 6'd42, 5'd1);
		// inverted x bounds touch nothing
		queue_light(16'h0000, 24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607,
			17'd0);
		// far off screen to the left lands in column 0
		queue_light(16'h5A5A, -24'sd8388608, -24'sd8388608, tile_coord(5, 0), tile_coord(5, 0),
			17'd0);
		queue_read(6'd0, 6'd5, 5'd1);
		// exact tile edges at 0.0, -1.0 and +1.0
		queue_light(16'hA5A5, 24'sd0, 24'sd0, -24'sd65536, -24'sd65536, 17'h08000);
		queue_light(16'h1234, 24'sd65536, 24'sd65536, 24'sd8388607, 24'sd8388607,
			tlb_pkg::DEPTH_ONE);
		queue_read(6'd32, 6'd0, 5'd1);
		queue_read(6'd63, 6'd63, 5'd1);
		queue_read(6'd63, 6'd63, 5'd30);
		queue_op(tlb_pkg::FUNC_CLEAR);
		queue_read(6'd32, 6'd0, 5'd0);
		// just outside -1.0 on both axes
		queue_light(16'hFFFF, -24'sd65537, -24'sd65535, -24'sd65537, -24'sd65535, 17'd1);
		queue_read(6'd1, 6'd1, 5'd0);
		hold_at = stim_items.size();

		// reads that pile up behind the long receiver hold-off
		for (int i = 0; i < 12; i++)
			queue_read(6'($urandom_range(0, 1)), 6'($urandom_range(0, 1)), rand_slot());

		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			hot_x = $urandom_range(0, 63);
			hot_y = $urandom_range(0, 63);
			// often pour enough lights onto one tile to fill or overflow its list
			if ($urandom_range(0, 1) == 0) begin
				fill_n = $urandom_range(31, 40);
				for (int k = 0; k < fill_n; k++)
					queue_light(16'($urandom()), tile_coord(hot_x, 0), tile_coord(hot_x, 0),
						tile_coord(hot_y, 0), tile_coord(hot_y, 0), rand_depth());
				n_rand += fill_n;
			end
			seg_left = $urandom_range(40, 100);
			while (seg_left > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					queue_op(tlb_pkg::FUNC_CLEAR);
				end else if (pick < 3) begin
					queue_op(FUNC_SPARE);
					continue;
				end else if (pick < 8) begin
					queue_light(16'($urandom()), 24'($urandom()), 24'($urandom()),
						24'($urandom()), 24'($urandom()), 17'($urandom()));
				end else if (pick < 55) begin
					cx = hot_x + $urandom_range(0, 2) - 1;
					cy = hot_y + $urandom_range(0, 2) - 1;
					wx = $urandom_range(0, 1);
					wy = $urandom_range(0, 1);
					queue_light(16'($urandom()), tile_coord(cx, $urandom_range(0, 2047)),
						tile_coord(cx + wx, $urandom_range(0, 2047)),
						tile_coord(cy, $urandom_range(0, 2047)),
						tile_coord(cy + wy, $urandom_range(0, 2047)), rand_depth());
				end else if (pick < 90) begin
					queue_read(near_tile(hot_x, 1), near_tile(hot_y, 1), rand_slot());
				end else begin
					queue_read(6'($urandom()), 6'($urandom()), rand_slot());
				end
				seg_left--;
				n_rand++;
			end
		end
		// end on a read so the last result closes the run
		queue_read(6'($urandom()), 6'($urandom()), rand_slot());
		stim_total = stim_items.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() != 0 || expected_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tiled_light_binner_unit: match");
		else
			$display("tiled_light_binner_unit: mismatch");
		$finish;
	end

endmodule
